// ===== hdl/coti_pkg.sv =====
// Shared constants, codes and control types of the complex operator table interpolator.
package coti_pkg;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_HALF_LEN = 8;
    localparam int COEFF_BITS   = 32;

    localparam int ROW_SIZE     = MAX_HALF_LEN * MAX_HALF_LEN;
    localparam int TABLE_DEPTH  = MAX_ROWS * ROW_SIZE;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int ROW_W        = $clog2(MAX_ROWS);
    localparam int CNT_W        = $clog2(ROW_SIZE + 1);
    localparam int HL_W         = $clog2(MAX_HALF_LEN + 1);
    localparam int F_BITS       = 16;
    localparam int PROD_W       = COEFF_BITS + F_BITS + 2;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_INTERP = 1'b1;

    localparam logic [2:0] CFG_K_MIN      = 3'd0;
    localparam logic [2:0] CFG_INV_STEP   = 3'd1;
    localparam logic [2:0] CFG_HALF_LEN_X = 3'd2;
    localparam logic [2:0] CFG_HALF_LEN_Y = 3'd3;
    localparam logic [2:0] CFG_ROW_COUNT  = 3'd4;

    typedef struct packed {
        logic             load_we;
        logic             capture;
        logic             mul_en;
        logic             setup_en;
        logic             issue;
        logic [CNT_W-1:0] tap;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] size;
        logic             pipe_busy;
    } t_status;

endpackage

// ===== hdl/coti_ctrl.sv =====
// Controller state machine that sequences position setup and the tap stream of an item.
module coti_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_func,
    output logic              o_busy,
    output coti_pkg::t_cmd    o_cmd,
    input  coti_pkg::t_status i_status
);
    import coti_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_SETUP  = 5'b00100,
        S_STREAM = 5'b01000,
        S_DRAIN  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_tap, n_tap;
    logic [CNT_W-1:0] r_size, n_size;
    logic             tap_last;

    assign tap_last = (r_tap == r_size - CNT_W'(1));
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_size  = r_size;
        o_cmd   = '0;
        o_cmd.tap  = r_tap;
        o_cmd.last = tap_last;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == FUNC_INTERP) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup_en = 1'b1;
                n_size  = i_status.size;
                n_tap   = '0;
                n_state = S_STREAM;
            end
            S_STREAM: begin
                o_cmd.issue = 1'b1;
                if (tap_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_tap = r_tap + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_size  <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_size  <= n_size;
        end
    end

`ifndef ASSERT_OFF
    a_last_tap_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) && tap_last |=> (r_state == S_DRAIN))
        else $error("stream did not end after the last tap");
    a_tap_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_tap < r_size))
        else $error("tap issued beyond the operator size");
`endif

endmodule

// ===== hdl/coti_dp.sv =====
// Datapath: configuration registers, operator table, position setup and interpolation pipeline.
module coti_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_wdata,
    input  logic [7:0]           i_row,
    input  logic [5:0]           i_tap,
    input  logic signed [31:0]   i_load_real,
    input  logic signed [31:0]   i_load_imag,
    input  logic [31:0]          i_wavenumber,
    input  logic                 i_conjugate,
    input  coti_pkg::t_cmd       i_cmd,
    output coti_pkg::t_status    o_status,
    output logic signed [31:0]   o_coeff_real,
    output logic signed [31:0]   o_coeff_imag,
    output logic [5:0]           o_tap_index,
    output logic                 o_last,
    output logic                 o_out_of_range,
    output logic                 o_strobe
);
    import coti_pkg::*;

    localparam logic signed [COEFF_BITS-1:0] CMAX = {1'b0, {(COEFF_BITS - 1){1'b1}}};
    localparam logic signed [COEFF_BITS-1:0] CMIN = {1'b1, {(COEFF_BITS - 1){1'b0}}};
    localparam logic signed [PROD_W-1:0]     RND  = PROD_W'(1 << (F_BITS - 1));

    function automatic logic [HL_W-1:0] clamp_len(input logic [3:0] v);
        logic [HL_W-1:0] res;
        if (v == 4'd0) begin
            res = HL_W'(1);
        end else if (32'(v) > MAX_HALF_LEN) begin
            res = HL_W'(MAX_HALF_LEN);
        end else begin
            res = HL_W'(v);
        end
        return res;
    endfunction

    logic [31:0] r_k_min, r_inv_step;
    logic [3:0]  r_half_x, r_half_y;
    logic [8:0]  r_row_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_min     <= 32'd0;
            r_inv_step  <= 32'd65536;
            r_half_x    <= 4'd8;
            r_half_y    <= 4'd8;
            r_row_count <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_K_MIN:      r_k_min     <= i_cfg_wdata;
                CFG_INV_STEP:   r_inv_step  <= i_cfg_wdata;
                CFG_HALF_LEN_X: r_half_x    <= i_cfg_wdata[3:0];
                CFG_HALF_LEN_Y: r_half_y    <= i_cfg_wdata[3:0];
                CFG_ROW_COUNT:  r_row_count <= i_cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    logic [ROW_W-1:0]  last_row;
    logic [2*HL_W-1:0] size_full;

    always_comb begin
        if (r_row_count == 9'd0) begin
            last_row = '0;
        end else if (32'(r_row_count) > MAX_ROWS) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(r_row_count - 9'd1);
        end
    end

    assign size_full     = clamp_len(r_half_x) * clamp_len(r_half_y);
    assign o_status.size = CNT_W'(size_full);

    // Position setup: difference, Q32.32 product, then row split and clamping.
    logic [31:0]       r_diff;
    logic              r_below, r_conj;
    logic [63:0]       r_prod;
    logic [ROW_W-1:0]  r_p, r_p2, p_sel;
    logic [F_BITS-1:0] r_f, f_sel;
    logic              r_oor, oor_sel;
    logic [31:0]       p_hi;

    assign p_hi = r_prod[63:32];

    always_comb begin
        if (r_below) begin
            p_sel   = '0;
            f_sel   = '0;
            oor_sel = 1'b1;
        end else if (p_hi >= 32'(last_row)) begin
            p_sel   = last_row;
            f_sel   = '0;
            oor_sel = 1'b1;
        end else begin
            p_sel   = ROW_W'(p_hi);
            f_sel   = r_prod[31:16];
            oor_sel = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_diff  <= i_wavenumber - r_k_min;
            r_below <= (i_wavenumber < r_k_min);
            r_conj  <= i_conjugate;
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_diff * r_inv_step;
        end
        if (i_cmd.setup_en) begin
            r_p   <= p_sel;
            r_p2  <= (p_sel < last_row) ? p_sel + ROW_W'(1) : p_sel;
            r_f   <= f_sel;
            r_oor <= oor_sel;
        end
    end

    // Operator table: one write port for loads, two read ports for the row pair.
    logic [2*COEFF_BITS-1:0] r_table [TABLE_DEPTH];
    logic [2*COEFF_BITS-1:0] r_rd1, r_rd2;
    logic [ADDR_W-1:0]       waddr, raddr1, raddr2;
    logic                    load_ok;

    assign load_ok = (32'(i_row) < MAX_ROWS) && (32'(i_tap) < ROW_SIZE);
    assign waddr   = ADDR_W'(32'(i_row) * ROW_SIZE + 32'(i_tap));
    assign raddr1  = ADDR_W'(32'(r_p) * ROW_SIZE + 32'(i_cmd.tap));
    assign raddr2  = ADDR_W'(32'(r_p2) * ROW_SIZE + 32'(i_cmd.tap));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && load_ok) begin
            r_table[waddr] <= {i_load_imag[COEFF_BITS-1:0], i_load_real[COEFF_BITS-1:0]};
        end
        if (i_cmd.issue) begin
            r_rd1 <= r_table[raddr1];
            r_rd2 <= r_table[raddr2];
        end
    end

    // Interpolation pipeline: difference, fraction product, rounding and output.
    logic                          r_rd_valid, r_d_valid, r_m_valid, r_out_valid;
    logic [CNT_W-1:0]              r_rd_tap, r_d_tap, r_m_tap;
    logic                          r_rd_last, r_d_last, r_m_last;
    logic signed [COEFF_BITS-1:0]  a_re, a_im, b_re, b_im;
    logic signed [COEFF_BITS-1:0]  r_d_a_re, r_d_a_im, r_m_a_re, r_m_a_im;
    logic signed [COEFF_BITS:0]    r_d_re, r_d_im;
    logic signed [PROD_W-1:0]      r_m_re, r_m_im;
    logic signed [PROD_W-1:0]      t_re, t_im, sh_re, sh_im;
    logic signed [COEFF_BITS-1:0]  val_re, val_im, out_im;

    assign a_re = $signed(r_rd1[COEFF_BITS-1:0]);
    assign a_im = $signed(r_rd1[2*COEFF_BITS-1:COEFF_BITS]);
    assign b_re = $signed(r_rd2[COEFF_BITS-1:0]);
    assign b_im = $signed(r_rd2[2*COEFF_BITS-1:COEFF_BITS]);

    assign t_re   = r_m_re + RND;
    assign t_im   = r_m_im + RND;
    assign sh_re  = t_re >>> F_BITS;
    assign sh_im  = t_im >>> F_BITS;
    assign val_re = r_m_a_re + COEFF_BITS'(sh_re);
    assign val_im = r_m_a_im + COEFF_BITS'(sh_im);

    always_comb begin
        if (r_conj) begin
            out_im = (val_im == CMIN) ? CMAX : -val_im;
        end else begin
            out_im = val_im;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tap  <= i_cmd.tap;
        r_rd_last <= i_cmd.last;
        r_d_tap   <= r_rd_tap;
        r_d_last  <= r_rd_last;
        r_d_a_re  <= a_re;
        r_d_a_im  <= a_im;
        r_d_re    <= (COEFF_BITS + 1)'(b_re) - (COEFF_BITS + 1)'(a_re);
        r_d_im    <= (COEFF_BITS + 1)'(b_im) - (COEFF_BITS + 1)'(a_im);
        r_m_tap   <= r_d_tap;
        r_m_last  <= r_d_last;
        r_m_a_re  <= r_d_a_re;
        r_m_a_im  <= r_d_a_im;
        r_m_re    <= $signed({1'b0, r_f}) * r_d_re;
        r_m_im    <= $signed({1'b0, r_f}) * r_d_im;
        o_coeff_real   <= 32'(val_re);
        o_coeff_imag   <= 32'(out_im);
        o_tap_index    <= 6'(r_m_tap);
        o_last         <= r_m_last;
        o_out_of_range <= r_oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_d_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid  <= i_cmd.issue;
            r_d_valid   <= r_rd_valid;
            r_m_valid   <= r_d_valid;
            r_out_valid <= r_m_valid;
        end
    end

    assign o_status.pipe_busy = r_rd_valid | r_d_valid | r_m_valid;
    assign o_strobe           = r_out_valid;

`ifndef ASSERT_OFF
    a_strobe_follows_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(r_m_valid) && $past(r_d_valid, 2))
        else $error("result strobe without a tap in the pipeline");
    a_issue_fills_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |=> r_rd_valid && o_status.pipe_busy)
        else $error("issued tap did not enter the read stage");
`endif

endmodule

// ===== hdl/complex_operator_table_interpolator.sv =====
// Top level of the complex operator table interpolator: controller and datapath.
//
// A load item (func 0) writes one complex tap into the operator table in the cycle it is
// accepted; busy stays low, so loads can be issued every cycle and return nothing. An
// interpolate item (func 1) raises busy while the MUL and SETUP states form the table
// position, one tap is read from the table each cycle for size taps, where size is the
// clamped half_len_x times half_len_y, and then the interpolation pipeline drains. The
// tap rate is set by the single table read of each row pair per cycle. Results leave
// the output register one per cycle with o_strobe high, taps in order, with o_last on
// the final tap. The receiver cannot stall: each result is present for exactly one
// cycle and must be taken then. Busy falls in the cycle right after the last result.
// Configuration must be written only while busy is low; the block does not enforce it.
module complex_operator_table_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [7:0]         i_row,
    input  logic [5:0]         i_tap,
    input  logic signed [31:0] i_load_real,
    input  logic signed [31:0] i_load_imag,
    input  logic [31:0]        i_wavenumber,
    input  logic               i_conjugate,
    output logic               o_strobe,
    output logic signed [31:0] o_coeff_real,
    output logic signed [31:0] o_coeff_imag,
    output logic [5:0]         o_tap_index,
    output logic               o_last,
    output logic               o_out_of_range
);
    import coti_pkg::*;

    t_cmd    cmd;
    t_status status;

    coti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    coti_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_row          (i_row),
        .i_tap          (i_tap),
        .i_load_real    (i_load_real),
        .i_load_imag    (i_load_imag),
        .i_wavenumber   (i_wavenumber),
        .i_conjugate    (i_conjugate),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_coeff_real   (o_coeff_real),
        .o_coeff_imag   (o_coeff_imag),
        .o_tap_index    (o_tap_index),
        .o_last         (o_last),
        .o_out_of_range (o_out_of_range),
        .o_strobe       (o_strobe)
    );

endmodule
